>>> hw/rtl/smi_pkg.sv
// ----------------------------------------------------------------------------
// smi_pkg
// shared widths, request/response types and helpers for the small matrix
// inverse block
// ----------------------------------------------------------------------------
package smi_pkg;

	localparam int MAX_SIZE  = 4;
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int ACC_W     = 64;
	localparam int SIZE_W    = 3;
	localparam int TOL_W     = 17;
	localparam int ADDR_W    = $clog2(MAX_SIZE * MAX_SIZE);
	localparam int IDX_W     = $clog2(MAX_SIZE);
	localparam int CNT_W     = $clog2(MAX_SIZE * MAX_SIZE + 1);

	typedef struct packed {
		logic                     start;
		logic signed [DATA_W-1:0] a;
		logic signed [ACC_W-1:0]  b;
	} mul_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [ACC_W-1:0] value;
	} mul_rsp_t;

	typedef struct packed {
		logic                    start;
		logic signed [ACC_W-1:0] cof;
		logic signed [ACC_W-1:0] det;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [DATA_W-1:0] quo;
		logic                     sat;
	} div_rsp_t;

	function automatic logic [ACC_W-1:0] mag64(input logic signed [ACC_W-1:0] v);
		return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
	endfunction

	function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
		return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
	endfunction

endpackage

>>> hw/rtl/smi_mul.sv
// ----------------------------------------------------------------------------
// smi_mul
// element times minor: 32x64 product on one 32x32 multiplier in two halves
// (low, then high), then round half away from zero and saturate to 64 bits
// ----------------------------------------------------------------------------
module smi_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  smi_pkg::mul_req_t req,
	output smi_pkg::mul_rsp_t rsp
);
	import smi_pkg::*;

	localparam int PROD_W = DATA_W + ACC_W;
	localparam int RSH_W  = PROD_W + 1 - FRAC_BITS;
	localparam logic [PROD_W:0]  RND_HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);
	localparam logic [ACC_W-1:0] LIM_NEG  = ACC_W'(1) << (ACC_W - 1);
	localparam logic [ACC_W-1:0] LIM_POS  = LIM_NEG - ACC_W'(1);

	localparam logic [1:0] MS_IDLE = 2'd0;
	localparam logic [1:0] MS_LO   = 2'd1;
	localparam logic [1:0] MS_HI   = 2'd2;
	localparam logic [1:0] MS_FIN  = 2'd3;

	logic [1:0]              state_q;
	logic                    done_q;
	logic [DATA_W-1:0]       ua_q;
	logic [ACC_W-1:0]        ub_q;
	logic                    neg_q;
	logic [2*DATA_W-1:0]     plo_q;
	logic [2*DATA_W-1:0]     phi_q;
	logic signed [ACC_W-1:0] res_q;

	logic [DATA_W-1:0]   ub_part;
	logic [2*DATA_W-1:0] prod;
	logic [PROD_W-1:0]   full;
	logic [PROD_W:0]     rnd;
	logic [RSH_W-1:0]    rsh;
	logic [ACC_W-1:0]    limit;
	logic [ACC_W-1:0]    mag_res;

	assign ub_part = (state_q == MS_HI) ? ub_q[ACC_W-1:DATA_W] : ub_q[DATA_W-1:0];
	assign prod    = ua_q * ub_part;
	assign full    = {phi_q, DATA_W'(0)} + PROD_W'(plo_q);
	assign rnd     = {1'b0, full} + RND_HALF;
	assign rsh     = rnd[PROD_W:FRAC_BITS];
	assign limit   = neg_q ? LIM_NEG : LIM_POS;
	assign mag_res = (rsh > RSH_W'(limit)) ? limit : rsh[ACC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MS_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				MS_IDLE: begin
					if (req.start) begin
						state_q <= MS_LO;
					end
				end
				MS_LO: state_q <= MS_HI;
				MS_HI: state_q <= MS_FIN;
				MS_FIN: begin
					state_q <= MS_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= MS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == MS_IDLE && req.start) begin
			ua_q  <= mag32(req.a);
			ub_q  <= mag64(req.b);
			neg_q <= req.a[DATA_W-1] ^ req.b[ACC_W-1];
		end
		if (state_q == MS_LO) begin
			plo_q <= prod;
		end
		if (state_q == MS_HI) begin
			phi_q <= prod;
		end
		if (state_q == MS_FIN) begin
			res_q <= neg_q ? ACC_W'(-mag_res) : mag_res;
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = res_q;

endmodule

>>> hw/rtl/smi_div.sv
// ----------------------------------------------------------------------------
// smi_div
// restoring divider: |cof| * 2^frac / |det|, one quotient bit a cycle,
// rounded half away from zero and saturated to 32 bits
// ----------------------------------------------------------------------------
module smi_div (
	input  logic              clk,
	input  logic              arst_n,
	input  smi_pkg::div_req_t req,
	output smi_pkg::div_rsp_t rsp
);
	import smi_pkg::*;

	localparam int NUM_W  = ACC_W + FRAC_BITS;
	localparam int QW     = 41;
	localparam int DCNT_W = $clog2(NUM_W + 1);
	localparam logic [QW:0] LIM_NEG = (QW + 1)'(1) << (DATA_W - 1);
	localparam logic [QW:0] LIM_POS = LIM_NEG - (QW + 1)'(1);

	localparam logic [1:0] DS_IDLE = 2'd0;
	localparam logic [1:0] DS_RUN  = 2'd1;
	localparam logic [1:0] DS_FIN  = 2'd2;

	logic [1:0]               state_q;
	logic                     done_q;
	logic [DCNT_W-1:0]        cnt_q;
	logic [NUM_W-1:0]         num_q;
	logic [ACC_W-1:0]         ud_q;
	logic [ACC_W-1:0]         r_q;
	logic [QW-1:0]            q_q;
	logic                     big_q;
	logic                     neg_q;
	logic signed [DATA_W-1:0] quo_q;
	logic                     sat_q;

	logic [ACC_W:0]  rs;
	logic [ACC_W:0]  diff;
	logic            ge;
	logic [QW-1:0]   q_next;
	logic            rnd;
	logic [QW:0]     qr;
	logic [QW:0]     limit;
	logic            sat;
	logic [QW:0]     qv;

	assign rs     = {r_q, num_q[NUM_W-1]};
	assign diff   = rs - {1'b0, ud_q};
	assign ge     = rs >= {1'b0, ud_q};
	assign q_next = {q_q[QW-2:0], ge};
	assign rnd    = {r_q, 1'b0} >= {1'b0, ud_q};
	assign qr     = {1'b0, q_q} + (QW + 1)'(rnd);
	assign limit  = neg_q ? LIM_NEG : LIM_POS;
	assign sat    = big_q || (qr > limit);
	assign qv     = sat ? limit : qr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				DS_IDLE: begin
					if (req.start) begin
						state_q <= DS_RUN;
						cnt_q   <= DCNT_W'(NUM_W);
					end
				end
				DS_RUN: begin
					cnt_q <= cnt_q - DCNT_W'(1);
					if (cnt_q == DCNT_W'(1)) begin
						state_q <= DS_FIN;
					end
				end
				DS_FIN: begin
					state_q <= DS_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= DS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DS_IDLE && req.start) begin
			num_q <= {mag64(req.cof), FRAC_BITS'(0)};
			ud_q  <= mag64(req.det);
			neg_q <= req.cof[ACC_W-1] ^ req.det[ACC_W-1];
			r_q   <= '0;
			q_q   <= '0;
			big_q <= 1'b0;
		end
		if (state_q == DS_RUN) begin
			r_q   <= ge ? diff[ACC_W-1:0] : rs[ACC_W-1:0];
			q_q   <= q_next;
			big_q <= big_q | q_next[QW-1];
			num_q <= num_q << 1;
		end
		if (state_q == DS_FIN) begin
			quo_q <= neg_q ? DATA_W'(-qv[DATA_W-1:0]) : qv[DATA_W-1:0];
			sat_q <= sat;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.sat  = sat_q;

endmodule

>>> hw/rtl/small_matrix_inverse_top.sv
// ----------------------------------------------------------------------------
// small_matrix_inverse_top
// adjugate inverse of a 2x2..4x4 Q16.16 matrix with determinant check
// ----------------------------------------------------------------------------
// input channel: one element word per handshake (in_valid / in_stall),
// row-major, n*n words per matrix; n comes from the size register.
// output channel (out_valid / out_stall): one singular word, or n*n inverse
// words in row-major order, each with the determinant; last marks the end.
// in_stall is high from the last element of a matrix until its final word
// has entered the output register; in_stall is low for the elements before that.
// compute steps: every cofactor-expansion term takes a scan, an element read
// and a product on the shared multiplier, and a 1x1 leaf adds a leaf read;
// the determinant and each cofactor are expanded this way, and every inverse
// word then runs the bit-serial divider before it is emitted. the next matrix
// is taken only after the final word.
// a stalled output word holds; the sequencer waits in its emit state until it is taken.
// reset: size 4, tolerance 1, load position 0, no output word pending.
// writing the size register restarts loading of the current matrix.
// ----------------------------------------------------------------------------
module small_matrix_inverse_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic                             cfg_index,
	input  logic [smi_pkg::TOL_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [smi_pkg::DATA_W-1:0] element_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [smi_pkg::DATA_W-1:0] inverse_value,
	output logic signed [smi_pkg::DATA_W-1:0] det_value,
	output logic                             singular,
	output logic                             overflow,
	output logic                             last
);
	import smi_pkg::*;

	localparam logic REG_MATRIX_SIZE = 1'b0;
	localparam logic REG_SING_TOL    = 1'b1;

	localparam logic [3:0] ST_LOAD    = 4'd0;
	localparam logic [3:0] ST_INIT    = 4'd1;
	localparam logic [3:0] ST_ONE_RD  = 4'd2;
	localparam logic [3:0] ST_ONE_WT  = 4'd3;
	localparam logic [3:0] ST_SCAN    = 4'd4;
	localparam logic [3:0] ST_LEAF_RD = 4'd5;
	localparam logic [3:0] ST_LEAF_WT = 4'd6;
	localparam logic [3:0] ST_EL_RD   = 4'd7;
	localparam logic [3:0] ST_EL_WT   = 4'd8;
	localparam logic [3:0] ST_MUL_WT  = 4'd9;
	localparam logic [3:0] ST_RESULT  = 4'd10;
	localparam logic [3:0] ST_DIV_WT  = 4'd11;
	localparam logic [3:0] ST_EMIT    = 4'd12;

	localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(1) << (ACC_W - 1);
	localparam logic signed [ACC_W-1:0] ACC_MAX = ~ACC_MIN;
	localparam logic signed [DATA_W-1:0] D_MIN  = DATA_W'(1) << (DATA_W - 1);
	localparam logic signed [DATA_W-1:0] D_MAX  = ~D_MIN;

	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b
	);
		logic [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? ACC_MIN : ACC_MAX;
		end
		return s[ACC_W-1:0];
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_sub(
		input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b
	);
		logic [ACC_W:0] s;
		s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? ACC_MIN : ACC_MAX;
		end
		return s[ACC_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] first_col(input logic [MAX_SIZE-1:0] m);
		logic [IDX_W-1:0] c;
		logic             hit;
		c   = '0;
		hit = 1'b0;
		for (int i = 0; i < MAX_SIZE; i++) begin
			if (!hit && m[i]) begin
				hit = 1'b1;
				c   = IDX_W'(i);
			end
		end
		return c;
	endfunction

	function automatic logic [IDX_W-1:0] row_of(
		input logic [IDX_W:0]   l,
		input logic             has_ex,
		input logic [IDX_W-1:0] ex
	);
		logic [IDX_W:0] r;
		r = (has_ex && l >= {1'b0, ex}) ? l + (IDX_W + 1)'(1) : l;
		return r[IDX_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] elem_addr(
		input logic [IDX_W-1:0]  r,
		input logic [IDX_W-1:0]  c,
		input logic [SIZE_W-1:0] n
	);
		logic [ADDR_W:0] t;
		t = (ADDR_W + 1)'(r) * (ADDR_W + 1)'(n) + (ADDR_W + 1)'(c);
		return t[ADDR_W-1:0];
	endfunction

	// control
	logic [3:0]        state_q;
	logic [SIZE_W-1:0] size_q;
	logic [TOL_W-1:0]  tol_q;
	logic [CNT_W-1:0]  load_cnt_q;
	logic              out_valid_q;
	logic              cof_mode_q;

	// storage and datapath
	logic signed [DATA_W-1:0] mem_q [MAX_SIZE*MAX_SIZE];
	logic signed [DATA_W-1:0] rd_q;
	logic [IDX_W-1:0]          lvl_q;
	logic [SIZE_W-1:0]         m_q;
	logic                      has_ex_q;
	logic [IDX_W-1:0]          ex_q;
	logic [MAX_SIZE-1:0]       top_mask_q;
	logic [MAX_SIZE-1:0]       cm_q  [MAX_SIZE];
	logic [IDX_W:0]            cur_q [MAX_SIZE];
	logic [IDX_W-1:0]          sel_q [MAX_SIZE];
	logic signed [ACC_W-1:0]   acc_q [MAX_SIZE];
	logic [MAX_SIZE-1:0]       par_q;
	logic signed [ACC_W-1:0]   sub_q;
	logic signed [ACC_W-1:0]   det_q;
	logic signed [DATA_W-1:0]  det32_q;
	logic                      det_sat_q;
	logic [IDX_W-1:0]          kr_q;
	logic [IDX_W-1:0]          kc_q;
	logic signed [DATA_W-1:0]  pend_inv_q;
	logic                      pend_sing_q;
	logic                      pend_ovf_q;
	logic                      pend_last_q;
	logic signed [DATA_W-1:0]  inv_q;
	logic signed [DATA_W-1:0]  det_out_q;
	logic                      sing_q;
	logic                      ovf_q;
	logic                      last_q;

	logic [SIZE_W-1:0]   n_eff;
	logic [SIZE_W-1:0]   n_m1;
	logic [CNT_W-1:0]    total;
	logic [MAX_SIZE-1:0] n_mask;
	logic                in_acc;
	logic [CNT_W-1:0]    wr_idx;
	logic [CNT_W-1:0]    wr_next;
	logic                scan_found;
	logic [IDX_W-1:0]    scan_col;
	logic [MAX_SIZE-1:0] leaf_mask;
	logic                leaf_now;
	logic [ADDR_W-1:0]   rd_addr;
	logic                det_fit;
	logic signed [DATA_W-1:0] det32;
	logic                is_sing;
	logic signed [ACC_W-1:0]  cof_adj;
	logic                out_free;
	logic                last_k;
	logic [IDX_W-1:0]    nkr;
	logic [IDX_W-1:0]    nkc;
	logic [IDX_W:0]      lvl_w;
	logic [IDX_W-1:0]    lvl_up;
	mul_req_t            mul_req;
	mul_rsp_t            mul_rsp;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	assign n_eff  = (size_q < SIZE_W'(2)) ? SIZE_W'(2) :
	                (size_q > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : size_q;
	assign n_m1   = n_eff - SIZE_W'(1);
	assign total  = CNT_W'(n_eff) * CNT_W'(n_eff);
	assign n_mask = MAX_SIZE'(((MAX_SIZE + 1)'(1) << n_eff) - (MAX_SIZE + 1)'(1));

	assign in_stall = (state_q != ST_LOAD);
	assign in_acc   = in_valid && !in_stall;
	assign wr_idx   = (load_cnt_q >= total) ? '0 : load_cnt_q;
	assign wr_next  = wr_idx + CNT_W'(1);

	assign lvl_w    = {1'b0, lvl_q};
	assign lvl_up   = lvl_q + IDX_W'(1);
	assign leaf_mask = cm_q[lvl_q] & ~(MAX_SIZE'(1) << sel_q[lvl_q]);
	assign leaf_now  = (m_q == SIZE_W'(lvl_q) + SIZE_W'(2));

	always_comb begin
		scan_found = 1'b0;
		scan_col   = '0;
		for (int i = 0; i < MAX_SIZE; i++) begin
			if (!scan_found && cm_q[lvl_q][i] && (IDX_W + 1)'(i) >= cur_q[lvl_q]) begin
				scan_found = 1'b1;
				scan_col   = IDX_W'(i);
			end
		end
	end

	always_comb begin
		unique case (state_q)
			ST_ONE_RD: rd_addr = elem_addr(row_of('0, has_ex_q, ex_q),
			                               first_col(cm_q[0]), n_eff);
			ST_LEAF_RD: rd_addr = elem_addr(row_of(lvl_w + (IDX_W + 1)'(1), has_ex_q, ex_q),
			                                first_col(leaf_mask), n_eff);
			default: rd_addr = elem_addr(row_of(lvl_w, has_ex_q, ex_q),
			                             sel_q[lvl_q], n_eff);
		endcase
	end

	assign det_fit = (sub_q[ACC_W-1:DATA_W-1] == '0) || (sub_q[ACC_W-1:DATA_W-1] == '1);
	assign det32   = det_fit ? sub_q[DATA_W-1:0] : (sub_q[ACC_W-1] ? D_MIN : D_MAX);
	assign is_sing = mag64(sub_q) <= ACC_W'(tol_q);
	assign cof_adj = (kr_q[0] ^ kc_q[0]) ?
	                 ((sub_q == ACC_MIN) ? ACC_MAX : ACC_W'(-sub_q)) : sub_q;

	assign out_free = !out_valid_q || !out_stall;
	assign last_k   = (kr_q == IDX_W'(n_m1)) && (kc_q == IDX_W'(n_m1));
	assign nkc      = (kc_q == IDX_W'(n_m1)) ? '0 : kc_q + IDX_W'(1);
	assign nkr      = (kc_q == IDX_W'(n_m1)) ? kr_q + IDX_W'(1) : kr_q;

	assign mul_req.start = (state_q == ST_EL_WT);
	assign mul_req.a     = rd_q;
	assign mul_req.b     = sub_q;

	assign div_req.start = (state_q == ST_RESULT) && cof_mode_q;
	assign div_req.cof   = cof_adj;
	assign div_req.det   = det_q;

	smi_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	smi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// element store
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mem_q[wr_idx[ADDR_W-1:0]] <= element_value;
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			size_q      <= SIZE_W'(MAX_SIZE);
			tol_q       <= TOL_W'(1);
			load_cnt_q  <= '0;
			out_valid_q <= 1'b0;
			cof_mode_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_MATRIX_SIZE: begin
						size_q     <= cfg_data[SIZE_W-1:0];
						load_cnt_q <= '0;
					end
					REG_SING_TOL: tol_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (wr_next == total) begin
							load_cnt_q <= '0;
							cof_mode_q <= 1'b0;
							state_q    <= ST_INIT;
						end else begin
							load_cnt_q <= wr_next;
						end
					end
				end
				ST_INIT: state_q <= (m_q == SIZE_W'(1)) ? ST_ONE_RD : ST_SCAN;
				ST_ONE_RD: state_q <= ST_ONE_WT;
				ST_ONE_WT: state_q <= ST_RESULT;
				ST_SCAN: begin
					if (scan_found) begin
						if (leaf_now) begin
							state_q <= ST_LEAF_RD;
						end
					end else begin
						state_q <= (lvl_q == '0) ? ST_RESULT : ST_EL_RD;
					end
				end
				ST_LEAF_RD: state_q <= ST_LEAF_WT;
				ST_LEAF_WT: state_q <= ST_EL_RD;
				ST_EL_RD: state_q <= ST_EL_WT;
				ST_EL_WT: state_q <= ST_MUL_WT;
				ST_MUL_WT: begin
					if (mul_rsp.done) begin
						state_q <= ST_SCAN;
					end
				end
				ST_RESULT: begin
					if (cof_mode_q) begin
						state_q <= ST_DIV_WT;
					end else if (is_sing) begin
						state_q <= ST_EMIT;
					end else begin
						cof_mode_q <= 1'b1;
						state_q    <= ST_INIT;
					end
				end
				ST_DIV_WT: begin
					if (div_rsp.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= pend_last_q ? ST_LOAD : ST_INIT;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc && wr_next == total) begin
					m_q        <= n_eff;
					has_ex_q   <= 1'b0;
					ex_q       <= '0;
					top_mask_q <= n_mask;
				end
			end
			ST_INIT: begin
				lvl_q     <= '0;
				cm_q[0]   <= top_mask_q;
				cur_q[0]  <= '0;
				acc_q[0]  <= '0;
				par_q[0]  <= 1'b0;
			end
			ST_ONE_WT: sub_q <= ACC_W'(rd_q);
			ST_SCAN: begin
				if (scan_found) begin
					sel_q[lvl_q] <= scan_col;
					cur_q[lvl_q] <= (IDX_W + 1)'(scan_col) + (IDX_W + 1)'(1);
					if (!leaf_now) begin
						lvl_q         <= lvl_up;
						cm_q[lvl_up]  <= cm_q[lvl_q] & ~(MAX_SIZE'(1) << scan_col);
						cur_q[lvl_up] <= '0;
						acc_q[lvl_up] <= '0;
						par_q[lvl_up] <= 1'b0;
					end
				end else begin
					sub_q <= acc_q[lvl_q];
					if (lvl_q != '0) begin
						lvl_q <= lvl_q - IDX_W'(1);
					end
				end
			end
			ST_LEAF_WT: sub_q <= ACC_W'(rd_q);
			ST_MUL_WT: begin
				if (mul_rsp.done) begin
					acc_q[lvl_q] <= par_q[lvl_q] ? sat_sub(acc_q[lvl_q], mul_rsp.value)
					                             : sat_add(acc_q[lvl_q], mul_rsp.value);
					par_q[lvl_q] <= ~par_q[lvl_q];
				end
			end
			ST_RESULT: begin
				if (!cof_mode_q) begin
					det_q     <= sub_q;
					det32_q   <= det32;
					det_sat_q <= !det_fit;
					if (is_sing) begin
						pend_inv_q  <= '0;
						pend_sing_q <= 1'b1;
						pend_ovf_q  <= !det_fit;
						pend_last_q <= 1'b1;
					end else begin
						kr_q       <= '0;
						kc_q       <= '0;
						m_q        <= n_m1;
						has_ex_q   <= 1'b1;
						ex_q       <= '0;
						top_mask_q <= n_mask & ~MAX_SIZE'(1);
					end
				end
			end
			ST_DIV_WT: begin
				if (div_rsp.done) begin
					pend_inv_q  <= div_rsp.quo;
					pend_sing_q <= 1'b0;
					pend_ovf_q  <= det_sat_q | div_rsp.sat;
					pend_last_q <= last_k;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					inv_q     <= pend_inv_q;
					det_out_q <= det32_q;
					sing_q    <= pend_sing_q;
					ovf_q     <= pend_ovf_q;
					last_q    <= pend_last_q;
					if (!pend_last_q) begin
						kr_q       <= nkr;
						kc_q       <= nkc;
						ex_q       <= nkc;
						top_mask_q <= n_mask & ~(MAX_SIZE'(1) << nkr);
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign inverse_value = inv_q;
	assign det_value     = det_out_q;
	assign singular      = sing_q;
	assign overflow      = ovf_q;
	assign last          = last_q;

endmodule
